@@ rtl/fcm_pkg.sv @@
// Shared constants, types and color tables of the false color map.
`timescale 1ns / 1ps
package fcm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int T_W = 17;
	localparam int NUM_W = 19;
	localparam int TOT_W = 27;
	localparam int Y_W = 12;
	localparam int C_W = 21;

	localparam logic [T_W-1:0] ONE = T_W'(65536);

	localparam logic [1:0] REG_RANGE_LOW = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_RAMP_SELECT = 2'd2;

	localparam logic [4:0] RAMP_COUNT = 5'd21;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [NUM_W-1:0] num;
		logic [2:0] n;
	} lerp_t;

	localparam logic [7:0] BLEND_COLS [4][3][3] = '{
		'{'{8'd200, 8'd60, 8'd0}, '{8'd250, 8'd160, 8'd110}, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd55, 8'd55, 8'd45}, '{8'd200, 8'd60, 8'd0}, '{8'd250, 8'd160, 8'd110}},
		'{'{8'd0, 8'd255, 8'd0}, '{8'd255, 8'd150, 8'd0}, '{8'd255, 8'd250, 8'd240}},
		'{'{8'd0, 8'd160, 8'd0}, '{8'd180, 8'd220, 8'd0}, '{8'd250, 8'd220, 8'd170}}
	};

	function automatic logic [NUM_W-1:0] clamp_unit(input logic signed [C_W-1:0] c);
		logic [NUM_W-1:0] r;
		if (c < 0) begin
			r = '0;
		end else if (c > $signed({{(C_W-T_W){1'b0}}, ONE})) begin
			r = NUM_W'(ONE);
		end else begin
			r = c[NUM_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/fcm_in_if.sv @@
// Sample input channel of the false color map.
`timescale 1ns / 1ps
interface fcm_in_if import fcm_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

@@ rtl/fcm_out_if.sv @@
// Color output channel of the false color map.
`timescale 1ns / 1ps
interface fcm_out_if import fcm_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/fcm_norm.sv @@
// Clamp of the sample and pipelined restoring division into a Q16 ratio.
`timescale 1ns / 1ps
module fcm_norm import fcm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic signed [SAMPLE_BITS-1:0] range_low,
	input logic signed [SAMPLE_BITS-1:0] range_high,
	input logic in_valid,
	output logic in_ready,
	input logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic out_valid,
	input logic out_ready,
	output logic [T_W-1:0] out_t
);

	logic vld_s1;
	logic [DIFF_W-1:0] num_s1;
	logic [DIFF_W-1:0] den_s1;
	logic en_s1;

	logic vld_sn [T_W];
	logic [DIFF_W-1:0] rem_sn [T_W];
	logic [DIFF_W-1:0] den_sn [T_W];
	logic [T_W-1:0] quo_sn [T_W];
	logic en_sn [T_W];

	logic signed [SAMPLE_BITS-1:0] clamped;
	logic signed [DIFF_W-1:0] span;
	logic signed [DIFF_W-1:0] offset;

	always_comb begin
		clamped = in_sample;
		if (in_sample < range_low) begin
			clamped = range_low;
		end
		if (in_sample > range_high) begin
			clamped = range_high;
		end
		span = DIFF_W'(range_high) - DIFF_W'(range_low);
		offset = DIFF_W'(clamped) - DIFF_W'(range_low);
	end

	assign en_s1 = !vld_s1 || en_sn[0];
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	// An empty or reversed range divides zero by one, which gives a zero ratio.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			if (range_high > range_low) begin
				num_s1 <= offset;
				den_s1 <= span;
			end else begin
				num_s1 <= '0;
				den_s1 <= DIFF_W'(1);
			end
		end
	end

	for (genvar j = 0; j < T_W; j++) begin : g_div
		logic prev_vld;
		logic [DIFF_W:0] trial;
		logic [DIFF_W-1:0] prev_den;
		logic [T_W-1:0] prev_quo;
		logic take;

		if (j == 0) begin : g_first
			assign prev_vld = vld_s1;
			assign trial = {1'b0, num_s1};
			assign prev_den = den_s1;
			assign prev_quo = '0;
		end else begin : g_next
			assign prev_vld = vld_sn[j-1];
			assign trial = {rem_sn[j-1], 1'b0};
			assign prev_den = den_sn[j-1];
			assign prev_quo = quo_sn[j-1];
		end

		if (j == T_W - 1) begin : g_last
			assign en_sn[j] = !vld_sn[j] || out_ready;
		end else begin : g_mid
			assign en_sn[j] = !vld_sn[j] || en_sn[j+1];
		end

		assign take = trial >= {1'b0, prev_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[j] <= 1'b0;
			end else if (en_sn[j]) begin
				vld_sn[j] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sn[j] && prev_vld) begin
				rem_sn[j] <= take ? DIFF_W'(trial - {1'b0, prev_den}) : trial[DIFF_W-1:0];
				den_sn[j] <= prev_den;
				quo_sn[j] <= {prev_quo[T_W-2:0], take};
			end
		end
	end

	assign out_valid = vld_sn[T_W-1];
	assign out_t = quo_sn[T_W-1];

endmodule

@@ rtl/fcm_ramp.sv @@
// Ramp segment selection, giving endpoints and a fraction for each channel.
`timescale 1ns / 1ps
module fcm_ramp import fcm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [4:0] ramp_select,
	input logic in_valid,
	output logic in_ready,
	input logic [T_W-1:0] in_t,
	output logic out_valid,
	input logic out_ready,
	output lerp_t out_terms [3]
);

	localparam logic signed [C_W-1:0] U = C_W'(65536);
	localparam logic signed [C_W-1:0] U2 = C_W'(131072);
	localparam logic signed [C_W-1:0] U3 = C_W'(196608);
	localparam logic signed [C_W-1:0] U4 = C_W'(262144);
	localparam logic signed [C_W-1:0] U6 = C_W'(393216);

	logic vld_s1;
	lerp_t terms_s1 [3];
	logic en_s1;

	logic [4:0] sel;
	logic signed [C_W-1:0] ts;
	logic signed [C_W-1:0] t2, t3, t4, t5, t6, t10;
	logic [2:0] k3, k4, k5, k6;
	logic low_half;
	logic signed [C_W-1:0] cr, cg, cb;
	logic blend;
	logic [1:0] set;
	logic signed [C_W-1:0] split;
	logic [2:0] rt;
	lerp_t terms [3];

	always_comb begin
		sel = (ramp_select >= RAMP_COUNT) ? ramp_select - RAMP_COUNT : ramp_select;
		ts = C_W'(in_t);
		t2 = ts * C_W'(2);
		t3 = ts * C_W'(3);
		t4 = ts * C_W'(4);
		t5 = ts * C_W'(5);
		t6 = ts * C_W'(6);
		t10 = ts * C_W'(10);
		k3 = (t3[18:16] > 3'd2) ? 3'd2 : t3[18:16];
		k4 = (t4[18:16] > 3'd3) ? 3'd3 : t4[18:16];
		k5 = (t5[18:16] > 3'd4) ? 3'd4 : t5[18:16];
		k6 = (t6[18:16] > 3'd5) ? 3'd5 : t6[18:16];
		low_half = (in_t < T_W'(32768));

		cr = U;
		cg = U;
		cb = U;
		case (sel)
			5'd1: begin
				case (k4)
					3'd0: begin cr = '0; cg = t4; cb = U; end
					3'd1: begin cr = '0; cg = U; cb = U2 - t4; end
					3'd2: begin cr = t4 - U2; cg = U; cb = '0; end
					default: begin cr = U; cg = U4 - t4; cb = '0; end
				endcase
			end
			5'd2: begin cr = ts; cg = '0; cb = U - ts; end
			5'd3: begin cr = ts; cg = ts; cb = ts; end
			5'd4: begin
				case (k6)
					3'd0: begin cr = U; cg = t6; cb = '0; end
					3'd1: begin cr = U2 - t6; cg = U; cb = '0; end
					3'd2: begin cr = '0; cg = U; cb = t6 - U2; end
					3'd3: begin cr = '0; cg = U4 - t6; cb = U; end
					3'd4: begin cr = t6 - U4; cg = '0; cb = U; end
					default: begin cr = U; cg = '0; cb = U6 - t6; end
				endcase
			end
			5'd5: begin cr = ts; cg = U; cb = '0; end
			5'd6: begin cr = ts; cg = U - ts; cb = ts; end
			5'd7: begin
				case (k4)
					3'd0: begin cr = '0; cg = t4; cb = U - t4; end
					3'd1: begin cr = t4 - U; cg = U2 - t4; cb = '0; end
					3'd2: begin cr = U3 - t4; cg = t4 - U2; cb = '0; end
					default: begin cr = '0; cg = U4 - t4; cb = t4 - U3; end
				endcase
			end
			5'd8: begin
				cr = low_half ? t2 : U2 - t2;
				cg = cr;
				cb = cr;
			end
			5'd9: begin
				case (k3)
					3'd0: begin cr = U - t3; cg = '0; cb = t3; end
					3'd1: begin cr = '0; cg = t3 - U; cb = U; end
					default: begin cr = t3 - U2; cg = U3 - t3; cb = U; end
				endcase
			end
			5'd10: begin
				case (k5)
					3'd0: begin cr = '0; cg = t5; cb = U; end
					3'd1: begin cr = '0; cg = U; cb = U2 - t5; end
					3'd2: begin cr = t5 - U2; cg = U; cb = '0; end
					3'd3: begin cr = U; cg = U4 - t5; cb = '0; end
					default: begin cr = U; cg = t5 - U4; cb = t5 - U4; end
				endcase
			end
			5'd14: begin cr = U; cg = U - ts; cb = '0; end
			5'd15: begin
				case (k4)
					3'd0: begin cr = '0; cg = t4; cb = U; end
					3'd1: begin cr = '0; cg = U; cb = U2 - t4; end
					3'd2: begin cr = t4 - U2; cg = U; cb = '0; end
					default: begin cr = U; cg = U; cb = t4 - U3; end
				endcase
			end
			5'd16: begin
				if (low_half) begin
					cr = '0; cg = t2; cb = U - t2;
				end else begin
					cr = t2 - U; cg = U2 - t2; cb = '0;
				end
			end
			5'd17: begin
				if (low_half) begin
					cr = U; cg = U - t2; cb = t2;
				end else begin
					cr = U2 - t2; cg = t2 - U; cb = U;
				end
			end
			5'd18: begin cr = '0; cg = ts; cb = U; end
			5'd19: begin cr = ts; cg = ts; cb = U; end
			default: begin cr = U; cg = U; cb = U; end
		endcase

		blend = (sel == 5'd11) || (sel == 5'd12) || (sel == 5'd13) || (sel == 5'd20);
		case (sel)
			5'd11: set = 2'd0;
			5'd12: set = 2'd1;
			5'd13: set = 2'd2;
			default: set = 2'd3;
		endcase
		rt = (sel == 5'd12) ? 3'd4 : 3'd3;
		split = {{(C_W-19){1'b0}}, rt, 16'd0};

		terms[0] = '{a: 8'd0, b: 8'd255, num: clamp_unit(cr), n: 3'd1};
		terms[1] = '{a: 8'd0, b: 8'd255, num: clamp_unit(cg), n: 3'd1};
		terms[2] = '{a: 8'd0, b: 8'd255, num: clamp_unit(cb), n: 3'd1};
		if (blend) begin
			for (int ci = 0; ci < 3; ci++) begin
				if (set == 2'd0) begin
					terms[ci] = '{a: BLEND_COLS[set][0][ci], b: BLEND_COLS[set][1][ci],
						num: NUM_W'(in_t), n: 3'd1};
				end else if (t10 < split) begin
					terms[ci] = '{a: BLEND_COLS[set][0][ci], b: BLEND_COLS[set][1][ci],
						num: t10[NUM_W-1:0], n: rt};
				end else begin
					terms[ci] = '{a: BLEND_COLS[set][1][ci], b: BLEND_COLS[set][2][ci],
						num: NUM_W'(t10 - split), n: 3'(4'd10 - {1'b0, rt})};
				end
			end
		end
	end

	assign en_s1 = !vld_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			terms_s1 <= terms;
		end
	end

	assign out_valid = vld_s1;
	assign out_terms = terms_s1;

endmodule

@@ rtl/fcm_blend.sv @@
// Interpolation between endpoints with round-to-nearest into 8-bit channels.
`timescale 1ns / 1ps
module fcm_blend import fcm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lerp_t in_terms [3],
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_chan [3]
);

	logic vld_s1, vld_s2, vld_s3;
	logic en_s1, en_s2, en_s3;
	logic [TOT_W-1:0] tot_s1 [3];
	logic [2:0] n_s1 [3];
	logic [Y_W-1:0] y_s2 [3];
	logic [2:0] n_s2 [3];
	logic [7:0] chan_s3 [3];

	logic [TOT_W-1:0] tot [3];
	logic [Y_W-1:0] y [3];
	logic [7:0] q [3];

	always_comb begin
		for (int ci = 0; ci < 3; ci++) begin
			logic [NUM_W-1:0] den;
			logic [TOT_W:0] sum;
			logic [Y_W+17:0] prod;
			logic [Y_W-1:0] quo;
			den = {in_terms[ci].n, 16'd0};
			tot[ci] = TOT_W'(in_terms[ci].a) * TOT_W'(den - in_terms[ci].num)
				+ TOT_W'(in_terms[ci].b) * TOT_W'(in_terms[ci].num);

			sum = {1'b0, tot_s1[ci]} + (TOT_W+1)'({n_s1[ci], 15'd0});
			y[ci] = sum[Y_W+15:16];

			prod = '0;
			quo = y_s2[ci];
			case (n_s2[ci])
				3'd3: begin
					prod = (Y_W+18)'(y_s2[ci]) * (Y_W+18)'(17'd43691);
					quo = prod[Y_W+16:17];
				end
				3'd4: quo = y_s2[ci] >> 2;
				3'd6: begin
					prod = (Y_W+18)'(y_s2[ci] >> 1) * (Y_W+18)'(17'd43691);
					quo = prod[Y_W+16:17];
				end
				3'd7: begin
					prod = (Y_W+18)'(y_s2[ci]) * (Y_W+18)'(17'd37450);
					quo = prod[Y_W+17:18];
				end
				default: quo = y_s2[ci];
			endcase
			q[ci] = (quo > Y_W'(255)) ? 8'd255 : quo[7:0];
		end
	end

	assign en_s3 = !vld_s3 || out_ready;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ci = 0; ci < 3; ci++) begin
			if (en_s1 && in_valid) begin
				tot_s1[ci] <= tot[ci];
				n_s1[ci] <= in_terms[ci].n;
			end
			if (en_s2 && vld_s1) begin
				y_s2[ci] <= y[ci];
				n_s2[ci] <= n_s1[ci];
			end
			if (en_s3 && vld_s2) begin
				chan_s3[ci] <= q[ci];
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_chan = chan_s3;

endmodule

@@ rtl/false_color_map_core.sv @@
// Top level: one sample is accepted per cycle when the output is free.
// Throughput is one sample per cycle while the output is free. The path
// runs through one clamp stage, 17 divider stages (one quotient bit each),
// one ramp stage and three interpolation stages, all registered.
// Reset clears all valid bits and sets range_low 0, range_high 32767, ramp 1.
`timescale 1ns / 1ps
module false_color_map_core import fcm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [SAMPLE_BITS-1:0] cfg_data,
	fcm_in_if.sink sample_in,
	fcm_out_if.source color_out
);

	logic signed [SAMPLE_BITS-1:0] range_low_q;
	logic signed [SAMPLE_BITS-1:0] range_high_q;
	logic [4:0] ramp_select_q;

	logic t_valid, t_ready;
	logic [T_W-1:0] t_val;
	logic r_valid, r_ready;
	lerp_t r_terms [3];
	logic [7:0] chans [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= '0;
			range_high_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			ramp_select_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW: range_low_q <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_RAMP_SELECT: ramp_select_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	fcm_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.range_low(range_low_q),
		.range_high(range_high_q),
		.in_valid(sample_in.valid),
		.in_ready(sample_in.ready),
		.in_sample(sample_in.sample_value),
		.out_valid(t_valid),
		.out_ready(t_ready),
		.out_t(t_val)
	);

	fcm_ramp u_ramp (
		.clk(clk),
		.arst_n(arst_n),
		.ramp_select(ramp_select_q),
		.in_valid(t_valid),
		.in_ready(t_ready),
		.in_t(t_val),
		.out_valid(r_valid),
		.out_ready(r_ready),
		.out_terms(r_terms)
	);

	fcm_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(r_valid),
		.in_ready(r_ready),
		.in_terms(r_terms),
		.out_valid(color_out.valid),
		.out_ready(color_out.ready),
		.out_chan(chans)
	);

	assign color_out.red = chans[0];
	assign color_out.green = chans[1];
	assign color_out.blue = chans[2];

endmodule

@@ tb/sv/tb_false_color_map_core.sv @@
// Self-checking testbench of false_color_map_core: directed and random samples over all ramps.
`timescale 1ns / 1ps
module tb_false_color_map_core;
	import fcm_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	typedef struct {
		logic [15:0] sample;
		bit typed;
		color_t color;
	} stim_row_t;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_RANGE_LOW;
	logic [SAMPLE_BITS-1:0] cfg_data = '0;

	fcm_in_if sample_ch();
	fcm_out_if color_ch();

	false_color_map_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_in(sample_ch.sink),
		.color_out(color_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [15:0] range_lo = 16'd0;
	logic [15:0] range_hi = 16'd32767;
	logic [4:0] ramp = 5'd1;

	color_t pending_colors[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int ready_gap = 0;
	bit sender_busy_mode = 0;
	bit receiver_busy_mode = 0;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		color_ch.ready = 1'b0;
	end

	function automatic logic [7:0] lerp8(longint a, longint b, longint num, longint den);
		longint total;
		longint q;
		if (num < 0) num = 0;
		if (num > den) num = den;
		total = a * (den - num) + b * num;
		q = (2 * total + den) / (2 * den);
		if (q < 0) q = 0;
		if (q > 255) q = 255;
		return q[7:0];
	endfunction

	function automatic color_t color_of(logic [15:0] s);
		longint lo, hi, v, t, u, r, g, b, c1, c2, c3, rt;
		int sel, k, set, ci;
		logic [7:0] ch [3];
		lo = longint'($signed(range_lo));
		hi = longint'($signed(range_hi));
		v = longint'($signed(s));
		t = 0;
		u = 65536;
		r = u;
		g = u;
		b = u;
		sel = int'(ramp) % 21;
		if (hi > lo) begin
			if (v < lo) v = lo;
			if (v > hi) v = hi;
			t = ((v - lo) * 65536) / (hi - lo);
		end
		if (sel == 11 || sel == 12 || sel == 13 || sel == 20) begin
			set = (sel == 11) ? 0 : (sel == 12) ? 1 : (sel == 13) ? 2 : 3;
			rt = (sel == 12) ? 4 : 3;
			for (ci = 0; ci < 3; ci++) begin
				c1 = BLEND_COLS[set][0][ci];
				c2 = BLEND_COLS[set][1][ci];
				c3 = BLEND_COLS[set][2][ci];
				if (set == 0) ch[ci] = lerp8(c1, c2, t, u);
				else if (t * 10 < rt * u) ch[ci] = lerp8(c1, c2, t * 10, rt * u);
				else ch[ci] = lerp8(c2, c3, t * 10 - rt * u, (10 - rt) * u);
			end
			return '{ch[0], ch[1], ch[2]};
		end
		case (sel)
			1, 15: begin
				k = int'((t * 4) / u);
				if (k > 3) k = 3;
				if (k == 0) begin r = 0; g = 4 * t; b = u; end
				else if (k == 1) begin r = 0; g = u; b = 2 * u - 4 * t; end
				else if (k == 2) begin r = 4 * t - 2 * u; g = u; b = 0; end
				else if (sel == 1) begin r = u; g = 4 * u - 4 * t; b = 0; end
				else begin r = u; g = u; b = 4 * t - 3 * u; end
			end
			2: begin r = t; g = 0; b = u - t; end
			3: begin r = t; g = t; b = t; end
			4: begin
				k = int'((t * 6) / u);
				if (k > 5) k = 5;
				if (k == 0) begin r = u; g = 6 * t; b = 0; end
				else if (k == 1) begin r = 2 * u - 6 * t; g = u; b = 0; end
				else if (k == 2) begin r = 0; g = u; b = 6 * t - 2 * u; end
				else if (k == 3) begin r = 0; g = 4 * u - 6 * t; b = u; end
				else if (k == 4) begin r = 6 * t - 4 * u; g = 0; b = u; end
				else begin r = u; g = 0; b = 6 * u - 6 * t; end
			end
			5: begin r = t; g = u; b = 0; end
			6: begin r = t; g = u - t; b = t; end
			7: begin
				k = int'((t * 4) / u);
				if (k > 3) k = 3;
				if (k == 0) begin r = 0; g = 4 * t; b = u - 4 * t; end
				else if (k == 1) begin r = 4 * t - u; g = 2 * u - 4 * t; b = 0; end
				else if (k == 2) begin r = 3 * u - 4 * t; g = 4 * t - 2 * u; b = 0; end
				else begin r = 0; g = 4 * u - 4 * t; b = 4 * t - 3 * u; end
			end
			8: begin
				if (t * 2 < u) r = 2 * t;
				else r = 2 * u - 2 * t;
				g = r;
				b = r;
			end
			9: begin
				k = int'((t * 3) / u);
				if (k > 2) k = 2;
				if (k == 0) begin r = u - 3 * t; g = 0; b = 3 * t; end
				else if (k == 1) begin r = 0; g = 3 * t - u; b = u; end
				else begin r = 3 * t - 2 * u; g = 3 * u - 3 * t; b = u; end
			end
			10: begin
				k = int'((t * 5) / u);
				if (k > 4) k = 4;
				if (k == 0) begin r = 0; g = 5 * t; b = u; end
				else if (k == 1) begin r = 0; g = u; b = 2 * u - 5 * t; end
				else if (k == 2) begin r = 5 * t - 2 * u; g = u; b = 0; end
				else if (k == 3) begin r = u; g = 4 * u - 5 * t; b = 0; end
				else begin r = u; g = 5 * t - 4 * u; b = g; end
			end
			14: begin r = u; g = u - t; b = 0; end
			16: begin
				if (t * 2 < u) begin r = 0; g = 2 * t; b = u - 2 * t; end
				else begin r = 2 * t - u; g = 2 * u - 2 * t; b = 0; end
			end
			17: begin
				if (t * 2 < u) begin r = u; g = u - 2 * t; b = 2 * t; end
				else begin r = 2 * u - 2 * t; g = 2 * t - u; b = u; end
			end
			18: begin r = 0; g = t; b = u; end
			19: begin r = t; g = t; b = u; end
			default: begin r = u; g = u; b = u; end
		endcase
		return '{lerp8(0, 255, r, u), lerp8(0, 255, g, u), lerp8(0, 255, b, u)};
	endfunction

	task automatic report(string field, logic [7:0] got, logic [7:0] want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		color_t want;
		if (sample_ch.valid && sample_ch.ready || color_ch.valid && color_ch.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (color_ch.valid && color_ch.ready) begin
			if (pending_colors.size() == 0) begin
				report("unexpected color transfer", color_ch.red, 8'd0);
			end else begin
				want = pending_colors.pop_front();
				if (color_ch.red !== want.red) report("red", color_ch.red, want.red);
				if (color_ch.green !== want.green) report("green", color_ch.green, want.green);
				if (color_ch.blue !== want.blue) report("blue", color_ch.blue, want.blue);
			end
			if (ready_gap == 0)
				ready_gap = receiver_busy_mode ? 0 : $urandom_range(0, 11);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			color_ch.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			color_ch.ready <= 1'b0;
			ready_gap--;
		end else begin
			color_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send(logic [15:0] s, bit typed, color_t want);
		int gap;
		gap = sender_busy_mode ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
		end
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= s;
		do @(posedge clk); while (!sample_ch.ready);
		pending_colors.push_back(typed ? want : color_of(s));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_RANGE_LOW: range_lo = data;
			REG_RANGE_HIGH: range_hi = data;
			REG_RAMP_SELECT: ramp = data[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		wait (pending_colors.size() == 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		longint lo, hi, n;
		lo = longint'($signed(range_lo));
		hi = longint'($signed(range_hi));
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return range_lo;
			2: return range_hi;
			3: begin
				n = $urandom_range(1, 10);
				return 16'(lo + (hi - lo) * longint'($urandom_range(0, n)) / n);
			end
			4: return range_lo + 16'($urandom_range(0, 3)) - 16'd1;
			default: return range_hi + 16'($urandom_range(0, 3)) - 16'd1;
		endcase
	endfunction

	stim_row_t directed [] = '{
		'{16'd0, 1, '{8'd0, 8'd0, 8'd255}},
		'{16'd32767, 1, '{8'd255, 8'd0, 8'd0}},
		'{16'h8000, 1, '{8'd0, 8'd0, 8'd255}},
		'{16'hFFFF, 1, '{8'd0, 8'd0, 8'd255}},
		'{16'd8192, 0, '0},
		'{16'd16384, 0, '0},
		'{16'd24576, 0, '0},
		'{16'd8191, 0, '0},
		'{16'd1, 0, '0},
		'{16'd32766, 0, '0},
		'{16'h5555, 0, '0},
		'{16'h2AAA, 0, '0}
	};

	initial begin
		int ph, i;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[j]) send(directed[j].sample, directed[j].typed, directed[j].color);
		drain();
		for (ph = 0; ph < 34; ph++) begin
			case (ph % 6)
				0: begin write_reg(REG_RANGE_LOW, 16'h8000); write_reg(REG_RANGE_HIGH, 16'h7FFF); end
				1: begin
					write_reg(REG_RANGE_LOW, 16'($urandom));
					write_reg(REG_RANGE_HIGH, range_lo + 16'($urandom_range(1, 200)));
				end
				2: begin write_reg(REG_RANGE_LOW, 16'($urandom)); write_reg(REG_RANGE_HIGH, range_lo); end
				3: begin
					write_reg(REG_RANGE_LOW, 16'($urandom_range(0, 32767)));
					write_reg(REG_RANGE_HIGH, 16'h8000 + 16'($urandom_range(0, 32767)));
				end
				4: begin write_reg(REG_RANGE_LOW, 16'($urandom)); write_reg(REG_RANGE_HIGH, 16'($urandom)); end
				default: begin write_reg(REG_RANGE_LOW, 16'd0); write_reg(REG_RANGE_HIGH, 16'h7FFF); end
			endcase
			write_reg(REG_RAMP_SELECT, {11'($urandom), (ph < 32) ? 5'(ph) : 5'($urandom)});
			if (ph == 5) write_reg(2'd3, 16'($urandom));
			sender_busy_mode = ($urandom_range(0, 3) == 0);
			receiver_busy_mode = ($urandom_range(0, 3) == 0);
			if (ph == 7) begin
				sender_busy_mode = 1;
				ready_gap = 300;
			end
			for (i = 0; i < ((ph == 7) ? 40 : 12); i++) send(pick_sample(), 0, '0);
			drain();
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_colors.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/fcm_pkg.sv
rtl/fcm_in_if.sv
rtl/fcm_out_if.sv
rtl/fcm_norm.sv
rtl/fcm_ramp.sv
rtl/fcm_blend.sv
rtl/false_color_map_core.sv
tb/sv/tb_false_color_map_core.sv
